// ===== design/smo_pkg.sv =====
// ----------------------------------------------------------------------------
// smo_pkg
// Shared constants and types for the scalar unit modulo the group order
// r = 2^254 + r0.
// ----------------------------------------------------------------------------
`default_nettype none

package smo_pkg;

  localparam int unsigned WORD_W   = 64;
  localparam int unsigned VAL_W    = 256;
  localparam int unsigned IN_DATA_W  = 512;
  localparam int unsigned OUT_DATA_W = 264;

  // low part of the order, 126 bits
  localparam logic [VAL_W-1:0] ORDER_LOW =
    {128'd0, 128'h2ACF567A912B7F03DCF2AC65396152C7};
  localparam logic [VAL_W-1:0] ORDER =
    {2'b01, 126'd0, ORDER_LOW[127:0]};
  // 4*r0; 4r wraps to this value modulo 2^256
  localparam logic [VAL_W-1:0] ORDER_LOW_X4 =
    {128'd0, 128'hAB3D59EA44ADFC0F73CAB194E5854B1C};
  // (r+1)/2
  localparam logic [VAL_W-1:0] HALF_PLUS =
    {3'b001, 125'd0, 128'h1567AB3D4895BF81EE7956329CB0A964};

  // fold tables indexed by the three bits at 2^254 and above:
  // FOLD_SUB holds h*r0, FOLD_ADD holds r - h*r0
  localparam logic [VAL_W-1:0] FOLD_SUB [8] = '{
    ORDER_LOW * 256'd0, ORDER_LOW * 256'd1, ORDER_LOW * 256'd2, ORDER_LOW * 256'd3,
    ORDER_LOW * 256'd4, ORDER_LOW * 256'd5, ORDER_LOW * 256'd6, ORDER_LOW * 256'd7
  };
  localparam logic [VAL_W-1:0] FOLD_ADD [8] = '{
    ORDER - ORDER_LOW * 256'd0, ORDER - ORDER_LOW * 256'd1,
    ORDER - ORDER_LOW * 256'd2, ORDER - ORDER_LOW * 256'd3,
    ORDER - ORDER_LOW * 256'd4, ORDER - ORDER_LOW * 256'd5,
    ORDER - ORDER_LOW * 256'd6, ORDER - ORDER_LOW * 256'd7
  };

  typedef enum logic [1:0] {
    MODE_SUB   = 2'd0,
    MODE_HALF  = 2'd1,
    MODE_BELOW = 2'd2
  } smo_mode_t;

endpackage

`default_nettype wire

// ===== design/smo_fold.sv =====
// ----------------------------------------------------------------------------
// smo_fold
// Partial fold of the bits at 2^254 and above using 2^254 = -r0 (mod r),
// with r added back when the difference goes negative.
// ----------------------------------------------------------------------------
`default_nettype none

module smo_fold (
  input  wire logic [smo_pkg::VAL_W-1:0] x,
  input  wire logic                      hi,
  output logic      [smo_pkg::VAL_W-1:0] y
);
  import smo_pkg::*;

  logic [2:0]       h;
  logic [VAL_W-1:0] t;
  logic [VAL_W:0]   diff;
  logic [VAL_W-1:0] wrap;

  assign h    = {hi, x[VAL_W-1:VAL_W-2]};
  assign t    = {2'b00, x[VAL_W-3:0]};
  // both outcomes side by side: t - h*r0, and t + (r - h*r0) for a borrow
  assign diff = {1'b0, t} - {1'b0, FOLD_SUB[h]};
  assign wrap = t + FOLD_ADD[h];
  assign y    = diff[VAL_W] ? wrap : diff[VAL_W-1:0];

endmodule

`default_nettype wire

// ===== design/scalar_mod_order_unit.sv =====
// ----------------------------------------------------------------------------
// scalar_mod_order_unit
// Stateless scalar unit modulo r = 2^254 + r0: subtract, halve, range test.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in_ stream: in_tuser carries the operation
//   (0 subtract, 1 halve, 2 test a below r), in_tdata operands a and b.
//   Each request yields exactly one result on the out_ stream: the reduced
//   value (zero for the range test) and the below-order flag.
//   Five register stages: input, difference/shift, constant add, fold,
//   final subtraction into the output register. One request is taken
//   every cycle while the output register is not stalled.
//   The pipeline advances as one unit: when the output register holds a
//   result that the receiver stalls, every stage holds and in_tready drops
//   in the same cycle; it rises again as soon as the result is taken.
//   Each stage after the input carries one 256-bit add or subtract (two side
//   by side in the difference stage and in the fold), which sets the clock.
//   Reset clears all stage valid bits; data registers are not reset.
//   Operation code 3 returns a result with every field zero.
// ----------------------------------------------------------------------------
`default_nettype none

module scalar_mod_order_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // in_tdata: a_w0, a_w1, a_w2, a_w3, b_w0, b_w1, b_w2, b_w3 (lowest first)
  input  wire logic [smo_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: mode
  input  wire logic [1:0]                     in_tuser,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // out_tdata: res_w0, res_w1, res_w2, res_w3, is_below_order, zero pad
  output logic      [smo_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready
);
  import smo_pkg::*;

  logic adv;

  // stage 0: input register
  logic             s0_vld_r;
  smo_mode_t        s0_mode_r;
  logic [VAL_W-1:0] s0_a_r, s0_b_r;

  // stage 1: difference or shift
  logic             s1_vld_r;
  smo_mode_t        s1_mode_r;
  logic [VAL_W-1:0] s1_val_r, s1_val_nxt;
  logic             s1_add_r, s1_add_nxt;
  logic             s1_flag_r, s1_flag_nxt;
  logic [VAL_W:0]   s1_diff, s1_below;

  // stage 2: conditional constant add
  logic             s2_vld_r;
  smo_mode_t        s2_mode_r;
  logic [VAL_W-1:0] s2_x_r;
  logic             s2_hi_r, s2_hi_nxt;
  logic             s2_flag_r;
  logic [VAL_W-1:0] s2_addk;
  logic [VAL_W:0]   s2_sum;

  // stage 3: fold
  logic             s3_vld_r;
  smo_mode_t        s3_mode_r;
  logic [VAL_W-1:0] s3_y_r, s3_y_nxt;
  logic             s3_flag_r;

  // stage 4: final subtraction into the output register
  logic             out_vld_r;
  logic [VAL_W-1:0] out_res_r, out_res_nxt;
  logic             out_flag_r;
  logic [VAL_W:0]   s4_red;

  // advance every stage whenever the output register is free or drains
  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r  <= 1'b0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r  <= in_tvalid;
      s1_vld_r  <= s0_vld_r;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      out_vld_r <= s3_vld_r;
    end
  end

  // stage 1: a - b with borrow, a >> 1 with odd bit, and a < r
  assign s1_diff  = {1'b0, s0_a_r} - {1'b0, s0_b_r};
  assign s1_below = {1'b0, s0_a_r} - {1'b0, ORDER};

  always_comb begin
    s1_val_nxt  = '0;
    s1_add_nxt  = 1'b0;
    s1_flag_nxt = 1'b0;
    case (s0_mode_r)
      MODE_SUB: begin
        s1_val_nxt = s1_diff[VAL_W-1:0];
        s1_add_nxt = s1_diff[VAL_W];
      end
      MODE_HALF: begin
        s1_val_nxt = {1'b0, s0_a_r[VAL_W-1:1]};
        s1_add_nxt = s0_a_r[0];
      end
      MODE_BELOW: begin
        s1_flag_nxt = s1_below[VAL_W];
      end
      default: begin
        s1_val_nxt = '0;
      end
    endcase
  end

  // stage 2: add 4r on a borrow (carry out lands at 2^256), or (r+1)/2 when odd
  always_comb begin
    s2_addk = '0;
    case (s1_mode_r)
      MODE_SUB:  s2_addk = s1_add_r ? ORDER_LOW_X4 : '0;
      MODE_HALF: s2_addk = s1_add_r ? HALF_PLUS : '0;
      default:   s2_addk = '0;
    endcase
  end

  assign s2_sum    = {1'b0, s1_val_r} + {1'b0, s2_addk};
  assign s2_hi_nxt = (s1_mode_r == MODE_SUB) && s2_sum[VAL_W];

  // stage 3: fold bits from 2^254 up
  smo_fold u_fold (
    .x  (s2_x_r),
    .hi (s2_hi_r),
    .y  (s3_y_nxt)
  );

  // stage 4: drop r once if the folded value is still at least r
  assign s4_red = {1'b0, s3_y_r} - {1'b0, ORDER};

  always_comb begin
    case (s3_mode_r)
      MODE_SUB, MODE_HALF: out_res_nxt = s4_red[VAL_W] ? s3_y_r : s4_red[VAL_W-1:0];
      default:             out_res_nxt = '0;
    endcase
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_mode_r  <= smo_mode_t'(in_tuser);
      s0_a_r     <= in_tdata[VAL_W-1:0];
      s0_b_r     <= in_tdata[2*VAL_W-1:VAL_W];

      s1_mode_r  <= s0_mode_r;
      s1_val_r   <= s1_val_nxt;
      s1_add_r   <= s1_add_nxt;
      s1_flag_r  <= s1_flag_nxt;

      s2_mode_r  <= s1_mode_r;
      s2_x_r     <= s2_sum[VAL_W-1:0];
      s2_hi_r    <= s2_hi_nxt;
      s2_flag_r  <= s1_flag_r;

      s3_mode_r  <= s2_mode_r;
      s3_y_r     <= s3_y_nxt;
      s3_flag_r  <= s2_flag_r;

      out_res_r  <= out_res_nxt;
      out_flag_r <= s3_flag_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_DATA_W-VAL_W-1){1'b0}}, out_flag_r, out_res_r};

endmodule

`default_nettype wire

// ===== design/smo_checker.sv =====
// ----------------------------------------------------------------------------
// smo_checker
// Port-level checks for scalar_mod_order_unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module smo_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tready,
  input wire logic [smo_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready
);
  import smo_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // requests are taken exactly when the output side can move
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not follow output drain");

  // every reduced value is below the order
  a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[VAL_W-1:0] < ORDER)
    else $error("result not fully reduced");

  // the range-test flag comes with zero value bits and no pad bits
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[VAL_W] |-> out_tdata[VAL_W-1:0] == '0)
    else $error("flagged result carries value bits");

  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_W-1:VAL_W+1] == '0)
    else $error("pad bits not zero");

endmodule

bind scalar_mod_order_unit smo_checker u_smo_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire

// ===== tb/sv/smo_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// smo_tb_pkg
// Result predictor and in-order scoreboard for the scalar unit modulo the
// group order r = 2^254 + r0.
// ----------------------------------------------------------------------------
`default_nettype none

package smo_tb_pkg;

  import smo_pkg::*;

  // operation code with no operation behind it: the block answers with zeros
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam logic [VAL_W-1:0] R0_VAL =
    {128'd0, 32'h2ACF567A, 32'h912B7F03, 32'hDCF2AC65, 32'h396152C7};
  localparam logic [VAL_W-1:0] GROUP_ORDER = {32'h40000000, 96'd0, R0_VAL[127:0]};
  // (r+1)/2
  localparam logic [VAL_W-1:0] HALF_ORDER_UP =
    {32'h20000000, 96'd0, 32'h1567AB3D, 32'h4895BF81, 32'hEE795632, 32'h9CB0A964};
  // 4r taken modulo 2^256
  localparam logic [VAL_W-1:0] FOUR_ORDER_WRAP = R0_VAL << 2;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             below_order;
  } scalar_result_t;

  class order_scoreboard;

    scalar_result_t pending[$];
    int unsigned    fail_count;

    function new();
      fail_count = 0;
    endfunction

    // Fold bits 256..254 back with 2^254 = -r0; add r once if that went negative.
    static function logic [VAL_W-1:0] fold_top(input logic [VAL_W-1:0] x,
                                              input logic carry_in);
      logic [2:0]       h;
      logic [VAL_W-1:0] t;
      logic [VAL_W-1:0] u;
      h = {carry_in, x[255:254]};
      t = {2'b00, x[253:0]};
      u = R0_VAL * {253'd0, h};
      if (t < u) return t + GROUP_ORDER - u;
      return t - u;
    endfunction

    static function logic [VAL_W-1:0] trim_once(input logic [VAL_W-1:0] x);
      if (x >= GROUP_ORDER) return x - GROUP_ORDER;
      return x;
    endfunction

    static function scalar_result_t predict_scalar(input logic [1:0] op,
                                                  input logic [VAL_W-1:0] a,
                                                  input logic [VAL_W-1:0] b);
      scalar_result_t   res;
      logic [VAL_W:0]   diff;
      logic [VAL_W:0]   sum;
      logic [VAL_W-1:0] half;
      res = '0;
      case (op)
        MODE_SUB: begin
          diff = {1'b0, a} - {1'b0, b};
          // on a borrow add 4r; the carry out feeds the fold
          if (diff[VAL_W]) sum = {1'b0, diff[VAL_W-1:0]} + {1'b0, FOUR_ORDER_WRAP};
          else sum = {1'b0, diff[VAL_W-1:0]};
          res.value = trim_once(fold_top(sum[VAL_W-1:0], sum[VAL_W]));
        end
        MODE_HALF: begin
          half = a >> 1;
          if (a[0]) half = half + HALF_ORDER_UP;
          res.value = trim_once(fold_top(half, 1'b0));
        end
        MODE_BELOW: begin
          res.below_order = (a < GROUP_ORDER);
        end
        default: begin
        end
      endcase
      return res;
    endfunction

    function void note_request(input logic [1:0] op, input logic [VAL_W-1:0] a,
                               input logic [VAL_W-1:0] b);
      pending.push_back(predict_scalar(op, a, b));
    endfunction

    function void check_result(input logic [OUT_DATA_W-1:0] word);
      scalar_result_t want;
      int             i;
      if (pending.size() == 0) begin
        $error("result with no request pending: %h", word);
        fail_count++;
        return;
      end
      want = pending.pop_front();
      for (i = 0; i < 4; i++) begin
        if (word[i*WORD_W +: WORD_W] !== want.value[i*WORD_W +: WORD_W]) begin
          $error("res_w%0d mismatch: expected %h, actual %h", i,
                 want.value[i*WORD_W +: WORD_W], word[i*WORD_W +: WORD_W]);
          fail_count++;
        end
      end
      if (word[VAL_W] !== want.below_order) begin
        $error("is_below_order mismatch: expected %b, actual %b",
               want.below_order, word[VAL_W]);
        fail_count++;
      end
    endfunction

    function int unsigned outstanding();
      return pending.size();
    endfunction

  endclass

endpackage

`default_nettype wire

// ===== tb/sv/tb_scalar_mod_order_unit.sv =====
// ----------------------------------------------------------------------------
// tb_scalar_mod_order_unit
// Streams subtract, halve and range-test requests through the scalar unit,
// predicts every result and checks it in order, under several idle and
// stall patterns on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_scalar_mod_order_unit;

  timeunit 1ns;
  timeprecision 1ps;

  import smo_pkg::*;
  import smo_tb_pkg::*;

  localparam int unsigned RESET_CYCLES    = 7;
  localparam int unsigned ITEMS_PER_PHASE = 458;
  // pipeline is 5 deep; give a little more before closing the run
  localparam int unsigned DRAIN_CYCLES    = 12;
  // cycles with no handshake on either stream before the run is abandoned
  localparam int unsigned STALL_LIMIT     = 2000;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [1:0]            in_tuser   = 2'd0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;

  // idle chances in percent, changed per phase by the stimulus
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  order_scoreboard results = new();

  scalar_mod_order_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Present one request, holding it until the block takes it. Idle cycles
  // go in front of it at the current sender idle rate.
  task automatic send_request(input logic [1:0] op, input logic [VAL_W-1:0] a,
                              input logic [VAL_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {b, a};
    @(posedge clk);
    // in_tready read here is the value seen by this edge
    while (!in_tready) @(posedge clk);
    results.note_request(op, a, b);
  endtask

  function automatic logic [VAL_W-1:0] random_wide();
    logic [VAL_W-1:0] v;
    int               i;
    for (i = 0; i < 8; i++) v[i*32 +: 32] = $urandom();
    return v;
  endfunction

  // small signed offset in -32..32
  function automatic logic [VAL_W-1:0] small_offset();
    return VAL_W'($urandom_range(64)) - VAL_W'(32);
  endfunction

  // Operands weighted toward the edges of the reduction: near 0, near
  // multiples of r, near 2^256, sparse limbs and single bits.
  function automatic logic [VAL_W-1:0] pick_operand();
    logic [VAL_W-1:0] v;
    int               i;
    v = random_wide();
    case ($urandom_range(9))
      0, 1: begin
      end
      2: v[255:254] = 2'b00;
      3: v = GROUP_ORDER + small_offset();
      4: v = GROUP_ORDER * VAL_W'($urandom_range(4)) + small_offset();
      5: v = '1 - VAL_W'($urandom_range(255));
      6: v = VAL_W'($urandom_range(255));
      // 2^254 plus random low bits, so near r on either side
      7: v = {2'b01, 126'd0, v[127:0]} - VAL_W'($urandom_range(1));
      8: begin
        for (i = 0; i < 8; i++) begin
          case ($urandom_range(2))
            0: v[i*32 +: 32] = 32'h0;
            1: v[i*32 +: 32] = 32'hFFFFFFFF;
            default: begin
            end
          endcase
        end
      end
      default: begin
        v = VAL_W'(1) << $urandom_range(255);
        if ($urandom_range(1) != 0) v = ~v;
      end
    endcase
    return v;
  endfunction

  // Stall the result stream at the current rate and check each result taken.
  initial begin : result_monitor
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) results.check_result(out_tdata);
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Abandon the run if neither stream moves for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
    logic [1:0]       op;
    int unsigned      phase;
    int unsigned      pick;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: operand extremes, borrow and fold corners, every operation,
    // the unused code, and b ignored outside subtract.
    send_request(MODE_SUB, '0, '0);
    send_request(MODE_SUB, '1, '0);
    send_request(MODE_SUB, '0, '1);
    send_request(MODE_SUB, '1, '1);
    send_request(MODE_SUB, '0, VAL_W'(1));
    send_request(MODE_SUB, GROUP_ORDER, '0);
    send_request(MODE_SUB, GROUP_ORDER - VAL_W'(1), '0);
    send_request(MODE_SUB, '0, GROUP_ORDER);
    send_request(MODE_SUB, GROUP_ORDER * VAL_W'(3), GROUP_ORDER);
    send_request(MODE_SUB, {2'b11, 254'd0}, '0);
    send_request(MODE_HALF, '0, '1);
    send_request(MODE_HALF, VAL_W'(1), '0);
    send_request(MODE_HALF, '1, '1);
    send_request(MODE_HALF, GROUP_ORDER, '0);
    send_request(MODE_HALF, GROUP_ORDER - VAL_W'(1), '1);
    send_request(MODE_HALF, GROUP_ORDER * VAL_W'(2) + VAL_W'(1), '0);
    send_request(MODE_BELOW, '0, '1);
    send_request(MODE_BELOW, GROUP_ORDER - VAL_W'(1), '0);
    send_request(MODE_BELOW, GROUP_ORDER, '1);
    send_request(MODE_BELOW, '1, '0);
    send_request(MODE_SPARE, '1, '1);
    send_request(MODE_SPARE, random_wide(), random_wide());

    // Random phases: no idling, sender idle, receiver stalling, both.
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 50 : (phase == 3) ? 22 : 0;
      recv_stall_pct = (phase == 2) ? 50 : (phase == 3) ? 22 : 0;
      repeat (ITEMS_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 40) op = MODE_SUB;
        else if (pick < 75) op = MODE_HALF;
        else if (pick < 95) op = MODE_BELOW;
        else op = MODE_SPARE;
        a = pick_operand();
        // keep subtract close to zero difference now and then
        case ($urandom_range(5))
          0: b = a;
          1: b = a + small_offset();
          2: b = a - VAL_W'($urandom_range(3));
          default: b = pick_operand();
        endcase
        send_request(op, a, b);
      end
    end
    in_tvalid <= 1'b0;

    // Drain: stop stalling, wait for every predicted result, then a margin
    // so a stray extra result is still caught.
    recv_stall_pct = 0;
    while (results.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (results.fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
